// ===== hw/rtl/rlcb_pkg.sv =====
// shared types, constants and helpers for the rgb led cube refresh engine
// no dependencies; imported by the front, queue, back and top modules
package rlcb_pkg;

   // cube geometry and frame store shape
   localparam int unsigned Colors       = 3;
   localparam int unsigned PlanesPerClr = 4;
   localparam int unsigned RowsPerLayer = 8;
   localparam int unsigned Layers       = 8;
   localparam int unsigned StoreRows    = Layers * RowsPerLayer;
   localparam int unsigned RowAddrBits  = $clog2(StoreRows);
   localparam int unsigned RowBits      = Colors * PlanesPerClr * 8;
   localparam int unsigned ByteSelBits  = $clog2(RowBits);

   // bytes emitted per refresh tick: three colors of eight rows, then the anode byte
   localparam int unsigned ColorBytes   = Colors * RowsPerLayer;
   localparam int unsigned TickBytes    = ColorBytes + 1;
   localparam int unsigned TickCntBits  = $clog2(TickBytes);

   // bit-angle modulation schedule
   localparam logic [6:0] ModStep1     = 7'd8;
   localparam logic [6:0] ModStep2     = 7'd24;
   localparam logic [6:0] ModStep3     = 7'd56;
   localparam logic [6:0] ModPeriod    = 7'd120;
   localparam logic [1:0] LastPlane    = 2'd3;
   localparam logic [7:0] LevelMax     = 8'd15;
   localparam logic [7:0] AnodeMsb     = 8'h80;

   // command queue depth
   localparam int unsigned QueueDepth  = 2;

   // item mode codes
   localparam logic ModeWrite = 1'b0;
   localparam logic ModeTick  = 1'b1;

   // one classified command handed from front to back
   typedef struct packed {
      logic       is_tick;
      logic [2:0] layer;
      logic [2:0] row;
      logic [2:0] column;
      logic [3:0] red;
      logic [3:0] green;
      logic [3:0] blue;
      logic [1:0] plane;
   } cmd_type;

   // clamp an 8-bit level to the 4-bit range
   function automatic logic [3:0] sat_level(input logic [7:0] level);
      logic [3:0] result;
      if (level > LevelMax) begin
         result = LevelMax[3:0];
      end else begin
         result = level[3:0];
      end
      return result;
   endfunction

endpackage

// ===== hw/rtl/rlcb_front.sv =====
// front end: takes items, saturates levels, tracks the modulation schedule
// depends on rlcb_pkg; feeds rlcb_cmd_queue
module rlcb_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             queue_full,
   input  logic             req_mode,
   input  logic [2:0]       req_voxel_layer,
   input  logic [2:0]       req_voxel_row,
   input  logic [2:0]       req_voxel_column,
   input  logic [7:0]       req_red_level,
   input  logic [7:0]       req_green_level,
   input  logic [7:0]       req_blue_level,
   output logic             busy,
   output logic             push,
   output rlcb_pkg::cmd_type push_cmd
);
   import rlcb_pkg::*;

   logic [6:0] mod_count_ff, mod_count_in;
   logic [1:0] plane_ff, plane_in;
   logic [2:0] layer_ff, layer_in;
   logic [1:0] tick_plane;
   logic [6:0] count_inc;
   logic       is_tick;

   // a transfer is taken whenever the queue has room
   assign busy    = queue_full;
   assign push    = start && !queue_full;
   assign is_tick = (req_mode == ModeTick);

   // plane steps at the schedule boundaries, before the count moves
   always_comb begin
      if (mod_count_ff == ModStep1 || mod_count_ff == ModStep2 ||
          mod_count_ff == ModStep3) begin
         tick_plane = plane_ff + 2'd1;
      end else begin
         tick_plane = plane_ff;
      end
      count_inc = mod_count_ff + 7'd1;
   end

   // next tick state
   always_comb begin
      mod_count_in = mod_count_ff;
      plane_in     = plane_ff;
      layer_in     = layer_ff;
      if (push && is_tick) begin
         layer_in = layer_ff + 3'd1;
         if (tick_plane == LastPlane && count_inc == ModPeriod) begin
            mod_count_in = '0;
            plane_in     = '0;
         end else begin
            mod_count_in = count_inc;
            plane_in     = tick_plane;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_count_ff <= '0;
         plane_ff     <= '0;
         layer_ff     <= '0;
      end else begin
         mod_count_ff <= mod_count_in;
         plane_ff     <= plane_in;
         layer_ff     <= layer_in;
      end
   end

   // build the command; a tick carries the scan layer and plane it must show
   always_comb begin
      push_cmd.is_tick = is_tick;
      push_cmd.layer   = is_tick ? layer_ff : req_voxel_layer;
      push_cmd.row     = req_voxel_row;
      push_cmd.column  = req_voxel_column;
      push_cmd.red     = sat_level(req_red_level);
      push_cmd.green   = sat_level(req_green_level);
      push_cmd.blue    = sat_level(req_blue_level);
      push_cmd.plane   = tick_plane;
   end

endmodule

// ===== hw/rtl/rlcb_cmd_queue.sv =====
// short fifo of classified commands between front and back
// depends on rlcb_pkg
module rlcb_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rlcb_pkg::cmd_type push_cmd,
   input  logic              pop,
   output rlcb_pkg::cmd_type head_cmd,
   output logic              full,
   output logic              empty
);
   import rlcb_pkg::*;

   localparam int unsigned PtrBits = $clog2(QueueDepth);
   localparam int unsigned CntBits = $clog2(QueueDepth + 1);

   cmd_type              entries_ff [QueueDepth];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntBits-1:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == CntBits'(QueueDepth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = entries_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/rlcb_back.sv =====
// back end: frame store, voxel read-modify-write and tick byte emission
// depends on rlcb_pkg; drains rlcb_cmd_queue
module rlcb_back (
   input  logic              clock,
   input  logic              reset,
   input  rlcb_pkg::cmd_type head_cmd,
   input  logic              queue_empty,
   output logic              pop,
   output logic              rsp_strobe,
   output logic [7:0]        rsp_shift_byte,
   output logic              rsp_latch_now
);
   import rlcb_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WR_READ,
      ST_WR_MODIFY,
      ST_TICK
   } state_type;

   state_type                state_ff, state_in;
   cmd_type                  cmd_ff, cmd_in;
   logic [TickCntBits-1:0]   cnt_ff, cnt_in;

   // frame store: one row holds all twelve bitplane bytes of one layer row
   logic [RowBits-1:0]       mem [StoreRows];
   logic [StoreRows-1:0]     row_valid_ff;
   logic [RowBits-1:0]       rd_data_ff;
   logic                     rd_valid_ff;
   logic [RowAddrBits-1:0]   rd_addr;
   logic                     wr_en;
   logic [RowBits-1:0]       wr_row;

   // emission pipeline
   logic                     p_valid_ff;
   logic                     p_anode_ff;
   logic [1:0]               p_color_ff;
   logic [ByteSelBits-1:0]   byte_base;
   logic [7:0]               plane_byte;
   logic                     rsp_strobe_ff;
   logic [7:0]               rsp_byte_ff;
   logic                     rsp_latch_ff;

   logic [3:0]               levels [Colors];

   // sequencer
   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      cnt_in   = cnt_ff;
      pop      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               pop    = 1'b1;
               cmd_in = head_cmd;
               cnt_in = '0;
               state_in = head_cmd.is_tick ? ST_TICK : ST_WR_READ;
            end
         end
         ST_WR_READ: begin
            state_in = ST_WR_MODIFY;
         end
         ST_WR_MODIFY: begin
            state_in = ST_IDLE;
         end
         ST_TICK: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == TickCntBits'(TickBytes - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      cmd_ff <= cmd_in;
   end

   // read address: a tick walks the eight rows of its layer per color
   always_comb begin
      if (state_ff == ST_TICK) begin
         rd_addr = {cmd_ff.layer, cnt_ff[2:0]};
      end else begin
         rd_addr = {cmd_ff.layer, cmd_ff.row};
      end
   end

   // merge the voxel's twelve bits into the row just read
   always_comb begin
      levels[0] = cmd_ff.red;
      levels[1] = cmd_ff.green;
      levels[2] = cmd_ff.blue;
      wr_row = rd_valid_ff ? rd_data_ff : '0;
      for (int c = 0; c < Colors; c++) begin
         for (int p = 0; p < PlanesPerClr; p++) begin
            wr_row[ByteSelBits'((c * PlanesPerClr + p) * 8) + ByteSelBits'(cmd_ff.column)]
               = levels[c][p];
         end
      end
      wr_en = (state_ff == ST_WR_MODIFY);
   end

   // memory array, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[rd_addr] <= wr_row;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // row valid bits stand in for clearing the store at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            row_valid_ff[rd_addr] <= 1'b1;
         end
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   // track which byte each memory read becomes
   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
         p_anode_ff <= 1'b0;
      end else begin
         p_valid_ff <= (state_ff == ST_TICK);
         p_anode_ff <= (state_ff == ST_TICK) &&
                       (cnt_ff == TickCntBits'(TickBytes - 1));
      end
      p_color_ff <= cnt_ff[4:3];
   end

   // select the active plane byte of the color
   always_comb begin
      byte_base  = ByteSelBits'({p_color_ff, cmd_ff.plane, 3'b000});
      plane_byte = rd_valid_ff ? rd_data_ff[byte_base +: 8] : 8'h00;
   end

   // result register, one transfer per strobe cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= p_valid_ff;
      end
      if (p_anode_ff) begin
         rsp_byte_ff  <= AnodeMsb >> cmd_ff.layer;
         rsp_latch_ff <= 1'b1;
      end else begin
         rsp_byte_ff  <= plane_byte;
         rsp_latch_ff <= 1'b0;
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_shift_byte = rsp_byte_ff;
   assign rsp_latch_now  = rsp_latch_ff;

endmodule

// ===== hw/rtl/rgb_led_cube_bam_refresh.sv =====
// Refresh engine for an 8x8x8 RGB LED cube with 4-bit bit-angle modulation.
// A write item (req_mode 0) stores one voxel's saturated levels; a tick item
// (req_mode 1) produces 25 byte transfers on consecutive cycles: eight red,
// eight green and eight blue row bytes of the active plane, then the anode
// byte with rsp_latch_now high. Items are taken while busy is low; a two-entry
// command queue sits between the front end and the frame store. The frame
// store has one read/write port, so the back end handles one item at a time:
// a write steps through the read and modify states, a tick reads one row per
// byte, and the first byte of a tick passes the sequencer state register, the
// store read register and the result register. The store reads as zero after
// reset with no clearing pass, through one valid bit per layer row. Results carry no
// backpressure: the receiver must take each byte in its strobe cycle.
// depends on rlcb_pkg, rlcb_front, rlcb_cmd_queue and rlcb_back
module rgb_led_cube_bam_refresh (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_mode,
   input  logic [2:0] req_voxel_layer,
   input  logic [2:0] req_voxel_row,
   input  logic [2:0] req_voxel_column,
   input  logic [7:0] req_red_level,
   input  logic [7:0] req_green_level,
   input  logic [7:0] req_blue_level,
   output logic       rsp_strobe,
   output logic [7:0] rsp_shift_byte,
   output logic       rsp_latch_now
);
   import rlcb_pkg::*;

   cmd_type push_cmd;
   cmd_type head_cmd;
   logic    push;
   logic    pop;
   logic    queue_full;
   logic    queue_empty;

   // accept and classify
   rlcb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .queue_full       (queue_full),
      .req_mode         (req_mode),
      .req_voxel_layer  (req_voxel_layer),
      .req_voxel_row    (req_voxel_row),
      .req_voxel_column (req_voxel_column),
      .req_red_level    (req_red_level),
      .req_green_level  (req_green_level),
      .req_blue_level   (req_blue_level),
      .busy             (busy),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   // decoupling queue
   rlcb_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   // frame store and byte emission
   rlcb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_cmd       (head_cmd),
      .queue_empty    (queue_empty),
      .pop            (pop),
      .rsp_strobe     (rsp_strobe),
      .rsp_shift_byte (rsp_shift_byte),
      .rsp_latch_now  (rsp_latch_now)
   );

endmodule
